/* rtl/core/sorted_priority_queue_core_assert.svh */
// Assertion macros used by the sorted priority queue checker
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/spq_pkg.sv */
// Shared types, widths and codes of the sorted priority queue
package spq_pkg;

   localparam int PRIO_W       = 31;
   localparam int DATA_W       = 16;
   localparam int ENTRY_W      = PRIO_W + DATA_W;
   localparam int STATUS_W     = 2;
   localparam int TOTAL_W      = 5;
   localparam int CAPACITY_DEF = 16;

   // Command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_PLACE,
      ST_HEAD,
      ST_LOAD,
      ST_RESULT
   } state_type;

endpackage

/* rtl/core/spq_ram.sv */
// Generic single-write, single-read RAM with registered read data
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/sorted_priority_queue_core.sv */
// Sorted priority queue: entry RAM walked by one comparator under a sequencer
//
// Usage:
//   Request channel (req_*): one word carries a command, a priority and a data
//   field. Insert places (priority, data) in ascending sorted order; delete
//   removes the first entry whose data equals req_entry_data.
//   Response channel (rsp_*): exactly one word per request with the status,
//   the number of entries held and the head (smallest) entry.
//   One request is in flight at a time: req_stall is high from acceptance
//   until the response word is taken.
//   Walk: entries live in a RAM with one read port and one compare unit;
//   each visited entry takes a read state, then a compare-and-move state.
//   An insert visits the entries that sort after the new one, plus the first
//   one that does not if any, then places the new entry; a delete visits
//   every entry held. A dropped insert (full) or a delete on an empty queue
//   skips the walk and goes straight to the head read.
//   Reset clears the entry count; the RAM needs no clearing since only slots
//   below the count are read. While rsp_stall is high the response word holds
//   and no new request is accepted.
module sorted_priority_queue_core #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [spq_pkg::PRIO_W-1:0]    req_entry_priority,
   input  logic [spq_pkg::DATA_W-1:0]    req_entry_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [spq_pkg::TOTAL_W-1:0]   rsp_entry_total,
   output logic                          rsp_head_valid,
   output logic [spq_pkg::PRIO_W-1:0]    rsp_head_priority,
   output logic [spq_pkg::DATA_W-1:0]    rsp_head_data
);

   import spq_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 cmd_ff, cmd_in;
   logic [PRIO_W-1:0]    prio_ff, prio_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic                 found_ff, found_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0]   rsp_total_ff, rsp_total_in;
   logic                 rsp_head_valid_ff, rsp_head_valid_in;
   logic [PRIO_W-1:0]    rsp_head_prio_ff, rsp_head_prio_in;
   logic [DATA_W-1:0]    rsp_head_data_ff, rsp_head_data_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_data;

   logic [ENTRY_W-1:0]   new_entry;
   logic                 sorts_after;
   logic                 key_match;
   logic                 match_now;
   logic                 last_slot;
   logic [CNT_W+TOTAL_W-1:0] total_wide;

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_spq_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared compare unit: {priority, data} ordering and key match
   assign new_entry   = {prio_ff, data_ff};
   assign sorts_after = rd_data > new_entry;
   assign key_match   = rd_data[DATA_W-1:0] == data_ff;
   assign match_now   = found_ff || key_match;
   assign last_slot   = CNT_W'(idx_ff) == (count_ff - CNT_W'(1));
   assign total_wide  = {{TOTAL_W{1'b0}}, count_ff};

   // Advance state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   // Hold request and response words
   always_ff @(posedge clock) begin
      idx_ff            <= idx_in;
      cmd_ff            <= cmd_in;
      prio_ff           <= prio_in;
      data_ff           <= data_in;
      status_ff         <= status_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_total_ff      <= rsp_total_in;
      rsp_head_valid_ff <= rsp_head_valid_in;
      rsp_head_prio_ff  <= rsp_head_prio_in;
      rsp_head_data_ff  <= rsp_head_data_in;
   end

   // Sequence one command over the stored entries
   always_comb begin
      state_in          = state_ff;
      count_in          = count_ff;
      idx_in            = idx_ff;
      cmd_in            = cmd_ff;
      prio_in           = prio_ff;
      data_in           = data_ff;
      found_in          = found_ff;
      status_in         = status_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_total_in      = rsp_total_ff;
      rsp_head_valid_in = rsp_head_valid_ff;
      rsp_head_prio_in  = rsp_head_prio_ff;
      rsp_head_data_in  = rsp_head_data_ff;
      wr_en             = 1'b0;
      wr_addr           = idx_ff;
      wr_data           = rd_data;
      rd_en             = 1'b0;
      rd_addr           = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               prio_in   = req_entry_priority;
               data_in   = req_entry_data;
               found_in  = 1'b0;
               status_in = STATUS_DONE;
               if (req_command == CMD_INSERT) begin
                  idx_in = IDX_W'(count_ff);
                  if (count_ff == CNT_W'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_HEAD;
                  end else if (count_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  idx_in = '0;
                  if (count_ff == '0) begin
                     status_in = STATUS_NOT_FOUND;
                     state_in  = ST_HEAD;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = (cmd_ff == CMD_INSERT) ? idx_ff - IDX_W'(1) : idx_ff;
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            if (cmd_ff == CMD_INSERT) begin
               // move a larger entry up one slot, or stop at the gap
               if (sorts_after) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff;
                  idx_in  = idx_ff - IDX_W'(1);
                  if (idx_ff == IDX_W'(1)) begin
                     state_in = ST_PLACE;
                  end else begin
                     state_in = ST_READ;
                  end
               end else begin
                  state_in = ST_PLACE;
               end
            end else begin
               // after the match, move each entry down one slot
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = idx_ff - IDX_W'(1);
               end
               found_in = match_now;
               if (last_slot) begin
                  if (match_now) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     status_in = STATUS_NOT_FOUND;
                  end
                  state_in = ST_HEAD;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end

         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = new_entry;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_HEAD;
         end

         ST_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_LOAD;
         end

         ST_LOAD: begin
            rsp_status_in     = status_ff;
            rsp_total_in      = total_wide[TOTAL_W-1:0];
            rsp_head_valid_in = count_ff != '0;
            if (count_ff != '0) begin
               rsp_head_prio_in = rd_data[ENTRY_W-1:DATA_W];
               rsp_head_data_in = rd_data[DATA_W-1:0];
            end else begin
               rsp_head_prio_in = '0;
               rsp_head_data_in = '0;
            end
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive the ports
   assign req_stall         = state_ff != ST_IDLE;
   assign rsp_valid         = state_ff == ST_RESULT;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_total   = rsp_total_ff;
   assign rsp_head_valid    = rsp_head_valid_ff;
   assign rsp_head_priority = rsp_head_prio_ff;
   assign rsp_head_data     = rsp_head_data_ff;

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks of the sorted priority queue, bound to the top level
`include "sorted_priority_queue_core_assert.svh"

module spq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_command,
   input logic [spq_pkg::PRIO_W-1:0]    req_entry_priority,
   input logic [spq_pkg::DATA_W-1:0]    req_entry_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [spq_pkg::STATUS_W-1:0]  rsp_status,
   input logic [spq_pkg::TOTAL_W-1:0]   rsp_entry_total,
   input logic                          rsp_head_valid,
   input logic [spq_pkg::PRIO_W-1:0]    rsp_head_priority,
   input logic [spq_pkg::DATA_W-1:0]    rsp_head_data
);

   import spq_pkg::*;

   // A stalled response word holds
   `SPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_entry_total) && $stable(rsp_head_priority) && $stable(rsp_head_data), "response word changed while stalled")

   // No request is taken while a response waits
   `SPQ_ASSERT_NOW(a_one_in_flight, clock, reset, rsp_valid, req_stall, "request accepted while response pending")

   // A response never follows its request in the next cycle
   `SPQ_ASSERT_NEXT(a_no_bypass, clock, reset, req_valid && !req_stall, !rsp_valid, "response appeared one cycle after request")

   // An empty queue reports a zero head
   `SPQ_ASSERT_NOW(a_empty_head, clock, reset, rsp_valid && !rsp_head_valid, rsp_head_priority == '0 && rsp_head_data == '0, "empty queue reports a nonzero head")

   // A dropped insert means the queue holds entries
   `SPQ_ASSERT_NOW(a_full_head, clock, reset, rsp_valid && rsp_status == STATUS_FULL, rsp_head_valid, "full status with an empty queue")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
